>>> rtl/hwd_pkg.sv
// shared types and constants for the one-level 2d haar decomposition
// used by hwd_filter and haar_wavelet_2d_decompose_core; no dependencies
`default_nettype none

package hwd_pkg;

  // configuration port
  localparam int CFG_W       = 11;
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // datapath widths
  localparam int PIXEL_W     = 8;
  localparam int LL_W        = 13;
  localparam int DET_W       = 14;
  localparam int STAGE1_W    = 25;   // (a +/- b) * coef, 15 fraction bits
  localparam int PAIR_W      = STAGE1_W + 1;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = PAIR_W + COEF_W;  // 30 fraction bits
  localparam int DROP_BITS   = 26;
  localparam int OUT_TDATA_W = 56;

  // 0.707 as 23167 / 32768
  localparam logic signed [COEF_W-1:0] COEF = 16'sd23167;

  // control bits that travel with a pixel into the filter
  typedef struct packed {
    logic valid;
    logic odd_row;
    logic odd_col;
    logic last;
  } tag_t;

  // unrounded block coefficients leaving the filter
  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic signed [PROD_W-1:0] ll;
    logic signed [PROD_W-1:0] lh;
    logic signed [PROD_W-1:0] hl;
    logic signed [PROD_W-1:0] hh;
  } prod_t;

endpackage

`default_nettype wire

>>> rtl/haar_wavelet_2d_decompose_core.sv
// top level of the one-level 2d haar decomposition of a streamed gray frame
// depends on hwd_pkg and hwd_filter; holds the line buffer and the raster indices
//
//   channel  | direction | word
//   s_axis   | in        | tdata[7:0] pixel
//   m_axis   | out       | tdata ll/lh/hl/hh of one 2x2 block, tlast frame_end
//   cfg      | in        | frame_width (index 0), frame_height (index 1)
//
// one pixel per clock unless stalled; results pass p1, s2, prod and output regs
// the line buffer is one single-port-style ram, written on even rows, read on odd
// a result waiting on m_axis halts the whole pipeline, and s_axis_tready with it
// reset clears indices and valid flags, sets a 1024x1024 frame; buffer not cleared
`default_nettype none

module haar_wavelet_2d_decompose_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // pixel
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  input  wire logic [hwd_pkg::PIXEL_W-1:0]         s_axis_tdata,
  // low_low[12:0], low_high[26:13], high_low[40:27], high_high[54:41], zero pad
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output      logic [hwd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output      logic                                m_axis_tlast,
  input  wire logic                                cfg_write,
  input  wire logic [hwd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [hwd_pkg::CFG_W-1:0]           cfg_data
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WCMP_W = (hwd_pkg::CFG_W > COL_W + 2) ? hwd_pkg::CFG_W : COL_W + 2;
  localparam int HCMP_W = (hwd_pkg::CFG_W > ROW_W + 2) ? hwd_pkg::CFG_W : ROW_W + 2;
  localparam logic [WCMP_W-1:0] W_MAX = WCMP_W'(MAX_WIDTH);
  localparam logic [HCMP_W-1:0] H_MAX = HCMP_W'(MAX_HEIGHT);
  localparam logic signed [hwd_pkg::PROD_W-1:0] HALF =
    hwd_pkg::PROD_W'(1) << (hwd_pkg::DROP_BITS - 1);

  logic [hwd_pkg::CFG_W-1:0]   frame_width;
  logic [hwd_pkg::CFG_W-1:0]   frame_height;
  logic [WCMP_W-1:0]           fw_ext;
  logic [HCMP_W-1:0]           fh_ext;
  logic [WCMP_W-1:0]           eff_width;
  logic [HCMP_W-1:0]           eff_height;

  logic [COL_W-1:0]            col_idx;
  logic [ROW_W-1:0]            row_idx;
  logic [WCMP_W-1:0]           col_p1;
  logic [WCMP_W-1:0]           col_p2;
  logic [HCMP_W-1:0]           row_p1;
  logic [HCMP_W-1:0]           row_p2;
  logic                        wrap_col;
  logic                        wrap_row;
  logic                        block_last;

  logic                        en;
  logic                        acc;

  logic [hwd_pkg::PIXEL_W-1:0] row_buffer [MAX_WIDTH];
  logic [hwd_pkg::PIXEL_W-1:0] rd_data;

  hwd_pkg::tag_t               p1_tag;
  logic [hwd_pkg::PIXEL_W-1:0] p1_pixel;
  hwd_pkg::prod_t              prod;

  logic [hwd_pkg::DET_W-1:0]   ll_rnd;
  logic                        out_valid;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= hwd_pkg::CFG_W'(1024);
      frame_height <= hwd_pkg::CFG_W'(1024);
    end else if (cfg_write) begin
      unique case (cfg_index)
        hwd_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        hwd_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign fw_ext = WCMP_W'(frame_width);
  assign fh_ext = HCMP_W'(frame_height);

  always_comb begin
    if (fw_ext < WCMP_W'(2)) begin
      eff_width = WCMP_W'(2);
    end else if (fw_ext > W_MAX) begin
      eff_width = W_MAX;
    end else begin
      eff_width = fw_ext;
    end
    if (fh_ext < HCMP_W'(2)) begin
      eff_height = HCMP_W'(2);
    end else if (fh_ext > H_MAX) begin
      eff_height = H_MAX;
    end else begin
      eff_height = fh_ext;
    end
  end

  // raster position
  assign col_p1     = WCMP_W'(col_idx) + WCMP_W'(1);
  assign col_p2     = WCMP_W'(col_idx) + WCMP_W'(2);
  assign row_p1     = HCMP_W'(row_idx) + HCMP_W'(1);
  assign row_p2     = HCMP_W'(row_idx) + HCMP_W'(2);
  assign wrap_col   = col_p1 >= eff_width;
  assign wrap_row   = row_p1 >= eff_height;
  assign block_last = (row_p2 >= eff_height) && (col_p2 >= eff_width);

  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en && !rst;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_idx <= '0;
      row_idx <= '0;
    end else if (acc) begin
      if (wrap_col) begin
        col_idx <= '0;
        row_idx <= wrap_row ? '0 : row_p1[ROW_W-1:0];
      end else begin
        col_idx <= col_p1[COL_W-1:0];
      end
    end
  end

  // line buffer: even rows write, odd rows read the pixel above
  always_ff @(posedge clk) begin
    if (acc && !row_idx[0]) begin
      row_buffer[col_idx] <= s_axis_tdata;
    end
    if (acc && row_idx[0]) begin
      rd_data <= row_buffer[col_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_tag.valid <= 1'b0;
    end else if (en) begin
      p1_tag.valid <= acc;
    end
    if (acc) begin
      p1_tag.odd_row <= row_idx[0];
      p1_tag.odd_col <= col_idx[0];
      p1_tag.last    <= block_last;
      p1_pixel       <= s_axis_tdata;
    end
  end

  hwd_filter u_filter (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .tag   (p1_tag),
    .top   (rd_data),
    .pixel (p1_pixel),
    .prod  (prod)
  );

  // round 30 fraction bits to 4, ties away from zero
  function automatic logic [hwd_pkg::DET_W-1:0] round_out(
    input logic signed [hwd_pkg::PROD_W-1:0] v
  );
    logic signed [hwd_pkg::PROD_W-1:0] biased;
    logic signed [hwd_pkg::PROD_W-1:0] shifted;
    biased  = v + (v[hwd_pkg::PROD_W-1] ? HALF - hwd_pkg::PROD_W'(1) : HALF);
    shifted = biased >>> hwd_pkg::DROP_BITS;
    return shifted[hwd_pkg::DET_W-1:0];
  endfunction

  assign ll_rnd = round_out(prod.ll);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= prod.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && prod.valid) begin
      m_axis_tdata <= {1'b0, round_out(prod.hh), round_out(prod.hl), round_out(prod.lh),
                       ll_rnd[hwd_pkg::LL_W-1:0]};
      m_axis_tlast <= prod.last;
    end
  end

  assign m_axis_tvalid = out_valid;

  // the column index restarts after the last column of a row
  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    acc && wrap_col |=> col_idx == '0)
    else $error("column index did not wrap");

  // the row index restarts after the last pixel of a frame
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    acc && wrap_col && wrap_row |=> row_idx == '0)
    else $error("row index did not wrap at frame end");

  // a new result only appears after the filter produced one
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(prod.valid))
    else $error("result word without a filter result");

  // a stalled pipeline takes no pixel and reads no line buffer word
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(rd_data) && $stable(col_idx))
    else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

>>> rtl/hwd_filter.sv
// vertical then horizontal haar butterflies, two register stages
// depends on hwd_pkg; the caller holds the line buffer and the rounding
`default_nettype none

module hwd_filter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire hwd_pkg::tag_t                 tag,
  input  wire logic [hwd_pkg::PIXEL_W-1:0]   top,
  input  wire logic [hwd_pkg::PIXEL_W-1:0]   pixel,
  output hwd_pkg::prod_t                     prod
);

  logic signed [hwd_pkg::PIXEL_W+1:0]      v_sum;
  logic signed [hwd_pkg::PIXEL_W+1:0]      v_diff;
  logic signed [hwd_pkg::STAGE1_W:0]       v_sum_p;
  logic signed [hwd_pkg::STAGE1_W:0]       v_diff_p;

  logic                                    s2_valid;
  logic                                    s2_odd_col;
  logic                                    s2_last;
  logic signed [hwd_pkg::STAGE1_W-1:0]     s2_sum;
  logic signed [hwd_pkg::STAGE1_W-1:0]     s2_diff;

  logic signed [hwd_pkg::STAGE1_W-1:0]     held_low_sum;
  logic signed [hwd_pkg::STAGE1_W-1:0]     held_high_sum;

  logic signed [hwd_pkg::PAIR_W-1:0]       a_ll;
  logic signed [hwd_pkg::PAIR_W-1:0]       a_lh;
  logic signed [hwd_pkg::PAIR_W-1:0]       a_hl;
  logic signed [hwd_pkg::PAIR_W-1:0]       a_hh;

  function automatic logic signed [hwd_pkg::PAIR_W-1:0] PAIR_EXT(
    input logic signed [hwd_pkg::STAGE1_W-1:0] v
  );
    return {v[hwd_pkg::STAGE1_W-1], v};
  endfunction

  // vertical step
  assign v_sum    = $signed({2'b00, top}) + $signed({2'b00, pixel});
  assign v_diff   = $signed({2'b00, top}) - $signed({2'b00, pixel});
  assign v_sum_p  = v_sum * hwd_pkg::COEF;
  assign v_diff_p = v_diff * hwd_pkg::COEF;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= tag.valid && tag.odd_row;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_odd_col <= tag.odd_col;
      s2_last    <= tag.last;
      s2_sum     <= v_sum_p[hwd_pkg::STAGE1_W-1:0];
      s2_diff    <= v_diff_p[hwd_pkg::STAGE1_W-1:0];
    end
  end

  // horizontal step pairs the held even column with the odd one
  assign a_ll = PAIR_EXT(held_low_sum) + PAIR_EXT(s2_sum);
  assign a_lh = PAIR_EXT(held_low_sum) - PAIR_EXT(s2_sum);
  assign a_hl = PAIR_EXT(held_high_sum) + PAIR_EXT(s2_diff);
  assign a_hh = PAIR_EXT(held_high_sum) - PAIR_EXT(s2_diff);

  always_ff @(posedge clk) begin
    if (en && s2_valid && !s2_odd_col) begin
      held_low_sum  <= s2_sum;
      held_high_sum <= s2_diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid <= 1'b0;
    end else if (en) begin
      prod.valid <= s2_valid && s2_odd_col;
    end
    if (en) begin
      prod.last <= s2_last;
      prod.ll   <= a_ll * hwd_pkg::COEF;
      prod.lh   <= a_lh * hwd_pkg::COEF;
      prod.hl   <= a_hl * hwd_pkg::COEF;
      prod.hh   <= a_hh * hwd_pkg::COEF;
    end
  end

endmodule

`default_nettype wire
